[rtl/gpsd_pkg.sv]
// ----------------------------------------------------------------------------
// gpsd_pkg
// Shared constants and controller/datapath interface types for the glyph
// point stream decoder.
// ----------------------------------------------------------------------------
package gpsd_pkg;

    // Sizing
    localparam int MAX_POINTS = 64;
    localparam int PTR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int BYTE_W     = 8;
    localparam int FLAG_W     = 6;
    localparam int COORD_W    = 16;
    localparam int IDX_W      = 6;
    localparam int COUNT_W    = 7;

    // Flag bit positions
    localparam int FLAG_ON_CURVE = 0;
    localparam int FLAG_X_SHORT  = 1;
    localparam int FLAG_Y_SHORT  = 2;
    localparam int FLAG_REPEAT   = 3;
    localparam int FLAG_X_SAME   = 4;
    localparam int FLAG_Y_SAME   = 5;

    // Commands from the controller
    typedef struct packed {
        logic accept;       // a byte transaction completes this cycle
        logic repeat_step;  // copy the held flag once
        logic settle_step;  // advance over a point that takes no byte
    } gpsd_cmd_t;

    // Status from the datapath
    typedef struct packed {
        logic phase_y;       // y coordinates are being decoded
        logic out_free;      // output register can take a point this cycle
        logic acc_repeat;    // the offered byte is a repeat count
        logic acc_settle;    // the offered byte ends the flags or completes a value
        logic rep_busy;      // repeat copies remain
        logic rep_to_settle; // repeat run filled the last point
        logic settle_exit;   // settling stops and the next byte is needed
        logic out_load;      // a point enters the output register
        logic cursor_over;   // cursor ran past the point count
    } gpsd_stat_t;

endpackage

[rtl/glyph_point_stream_decoder.sv]
// ----------------------------------------------------------------------------
// glyph_point_stream_decoder
// Decodes simple-glyph flag and coordinate bytes into absolute points.
//
//   channel  handshake                  payload
//   byte     byte_valid / byte_ready    glyph_byte, first_of_glyph, point_count
//   point    point_valid / point_ready  point_index, x_coord, y_coord,
//                                       on_curve, end_of_glyph
//
// A flag byte or a high delta byte needs no further step. A repeat count runs as
// an accept, a copy of the held flag per repeat up to the last point and a close.
// Ending the flags or completing a coordinate starts settling: it steps over each
// point that needs no byte and the x phase end, and stops at a byte-coded point.
// Y-phase bytes and y settling stall while the output register is full.
// Reset leaves the stores unwritten; every entry is written before it is read.
// ----------------------------------------------------------------------------
module glyph_point_stream_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                byte_valid,
    output logic                                byte_ready,
    input  logic [gpsd_pkg::BYTE_W-1:0]         glyph_byte,
    input  logic                                first_of_glyph,
    input  logic [gpsd_pkg::COUNT_W-1:0]        point_count,
    output logic                                point_valid,
    input  logic                                point_ready,
    output logic [gpsd_pkg::IDX_W-1:0]          point_index,
    output logic signed [gpsd_pkg::COORD_W-1:0] x_coord,
    output logic signed [gpsd_pkg::COORD_W-1:0] y_coord,
    output logic                                on_curve,
    output logic                                end_of_glyph
);
    import gpsd_pkg::*;

    gpsd_cmd_t  cmd;
    gpsd_stat_t stat;

    // Sequencer
    gpsd_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // Stores, accumulator and output register
    gpsd_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .glyph_byte     (glyph_byte),
        .first_of_glyph (first_of_glyph),
        .point_count    (point_count),
        .point_valid    (point_valid),
        .point_ready    (point_ready),
        .point_index    (point_index),
        .x_coord        (x_coord),
        .y_coord        (y_coord),
        .on_curve       (on_curve),
        .end_of_glyph   (end_of_glyph)
    );

`ifndef SYNTH
    // Never overwrite a point that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        stat.out_load |-> (!point_valid || point_ready))
        else $error("point register overwritten");

    // No byte is taken while a repeat run copies flags
    a_no_accept_in_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.repeat_step |-> !byte_ready)
        else $error("byte taken during repeat");

    // The cursor never runs past the point count
    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.cursor_over)
        else $error("cursor past point count");
`endif

endmodule

[rtl/gpsd_ctrl.sv]
// ----------------------------------------------------------------------------
// gpsd_ctrl
// Sequencer: takes bytes, runs flag repeats and settles over points that
// need no byte.
// ----------------------------------------------------------------------------
module gpsd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  gpsd_pkg::gpsd_stat_t stat,
    output gpsd_pkg::gpsd_cmd_t  cmd
);
    import gpsd_pkg::*;

    typedef enum logic [1:0] {
        ST_BYTE,
        ST_REPEAT,
        ST_SETTLE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Take a byte only when a point it may complete has room
    assign byte_ready = (state_reg == ST_BYTE) && (!stat.phase_y || stat.out_free);
    assign accept     = byte_valid && byte_ready;

    assign cmd.accept      = accept;
    assign cmd.repeat_step = (state_reg == ST_REPEAT);
    assign cmd.settle_step = (state_reg == ST_SETTLE);

    // Choose the next step
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_BYTE:
            begin
                if (accept)
                begin
                    if (stat.acc_repeat)
                        state_next = ST_REPEAT;
                    else if (stat.acc_settle)
                        state_next = ST_SETTLE;
                end
            end
            ST_REPEAT:
            begin
                if (!stat.rep_busy)
                    state_next = stat.rep_to_settle ? ST_SETTLE : ST_BYTE;
            end
            ST_SETTLE:
            begin
                if (stat.settle_exit)
                    state_next = ST_BYTE;
            end
            default: state_next = ST_BYTE;
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_BYTE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/gpsd_datapath.sv]
// ----------------------------------------------------------------------------
// gpsd_datapath
// Flag and x stores, point cursor, delta accumulator and output register.
// ----------------------------------------------------------------------------
module gpsd_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  gpsd_pkg::gpsd_cmd_t                 cmd,
    output gpsd_pkg::gpsd_stat_t                stat,
    input  logic [gpsd_pkg::BYTE_W-1:0]         glyph_byte,
    input  logic                                first_of_glyph,
    input  logic [gpsd_pkg::COUNT_W-1:0]        point_count,
    output logic                                point_valid,
    input  logic                                point_ready,
    output logic [gpsd_pkg::IDX_W-1:0]          point_index,
    output logic signed [gpsd_pkg::COORD_W-1:0] x_coord,
    output logic signed [gpsd_pkg::COORD_W-1:0] y_coord,
    output logic                                on_curve,
    output logic                                end_of_glyph
);
    import gpsd_pkg::*;

    typedef enum logic [1:0] {
        PH_FLAGS,
        PH_X,
        PH_Y,
        PH_DONE
    } phase_t;

    // Control state
    phase_t             phase_reg,   phase_next;
    logic [CNT_W-1:0]   cursor_reg,  cursor_next;
    logic [CNT_W-1:0]   total_reg,   total_next;
    logic               rep_reg,     rep_next;
    logic [BYTE_W-1:0]  rep_cnt_reg, rep_cnt_next;
    logic [FLAG_W-1:0]  held_reg,    held_next;
    logic               hbp_reg,     hbp_next;
    logic [BYTE_W-1:0]  hb_reg,      hb_next;
    logic [COORD_W-1:0] run_reg,     run_next;
    logic               out_valid_reg, out_valid_next;

    // Output payload
    logic [IDX_W-1:0]   out_idx_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic               out_on_reg;
    logic               out_last_reg;

    // Stores
    logic [FLAG_W-1:0]  flag_mem [MAX_POINTS];
    logic [COORD_W-1:0] x_mem    [MAX_POINTS];
    logic [FLAG_W-1:0]  flag_rd_reg;
    logic [COORD_W-1:0] x_rd_reg;
    logic               flag_we;
    logic [PTR_W-1:0]   flag_waddr;
    logic [FLAG_W-1:0]  flag_wdata;
    logic               x_we;
    logic [PTR_W-1:0]   rd_addr;

    // Byte decode
    logic [CNT_W-1:0]   count_clamp;
    logic [CNT_W-1:0]   total_eff;
    phase_t             phase_eff;
    logic [CNT_W-1:0]   cursor_eff;
    logic               rep_eff;
    logic               hbp_eff;
    logic               sel_x;
    logic               f_short;
    logic               f_same;
    logic               ph_xy;
    logic               at_end;
    logic               enter_x_on_byte;
    logic               commit_on_byte;
    logic               commit;
    logic [COORD_W-1:0] delta;
    logic [COORD_W-1:0] sum;
    logic               out_free;
    logic               out_load;

    // Clamp the latched point count to one through the store depth
    always_comb
    begin
        if (point_count == '0)
            count_clamp = CNT_W'(1);
        else if (point_count > COUNT_W'(MAX_POINTS))
            count_clamp = CNT_W'(MAX_POINTS);
        else
            count_clamp = CNT_W'(point_count);
    end

    // Values seen by an offered byte; a first byte restarts the glyph
    assign total_eff  = first_of_glyph ? count_clamp : total_reg;
    assign phase_eff  = first_of_glyph ? PH_FLAGS    : phase_reg;
    assign cursor_eff = first_of_glyph ? '0          : cursor_reg;
    assign rep_eff    = first_of_glyph ? 1'b0        : rep_reg;
    assign hbp_eff    = first_of_glyph ? 1'b0        : hbp_reg;

    // Current point's coordinate encoding
    assign sel_x   = (phase_reg == PH_X);
    assign f_short = sel_x ? flag_rd_reg[FLAG_X_SHORT] : flag_rd_reg[FLAG_Y_SHORT];
    assign f_same  = sel_x ? flag_rd_reg[FLAG_X_SAME]  : flag_rd_reg[FLAG_Y_SAME];
    assign ph_xy   = (phase_reg == PH_X) || (phase_reg == PH_Y);
    assign at_end  = (cursor_reg >= total_reg);

    assign enter_x_on_byte = (phase_eff == PH_FLAGS) && !rep_eff &&
                             !glyph_byte[FLAG_REPEAT] &&
                             ((cursor_eff + CNT_W'(1)) >= total_eff);
    assign commit_on_byte  = !first_of_glyph && ph_xy && (f_short || hbp_reg);

    assign out_free = !out_valid_reg || point_ready;

    // Next-state logic for decode, repeat and settle steps
    always_comb
    begin
        phase_next   = phase_reg;
        cursor_next  = cursor_reg;
        total_next   = total_reg;
        rep_next     = rep_reg;
        rep_cnt_next = rep_cnt_reg;
        held_next    = held_reg;
        hbp_next     = hbp_reg;
        hb_next      = hb_reg;
        run_next     = run_reg;
        flag_we      = 1'b0;
        flag_waddr   = cursor_reg[PTR_W-1:0];
        flag_wdata   = held_reg;
        commit       = 1'b0;
        delta        = '0;

        if (cmd.accept)
        begin
            total_next  = total_eff;
            phase_next  = phase_eff;
            cursor_next = cursor_eff;
            rep_next    = rep_eff;
            hbp_next    = hbp_eff;
            if (first_of_glyph)
            begin
                held_next = '0;
                hb_next   = '0;
                run_next  = '0;
            end
            case (phase_eff)
                PH_FLAGS:
                begin
                    if (rep_eff)
                    begin
                        rep_cnt_next = glyph_byte;
                    end
                    else
                    begin
                        flag_we     = 1'b1;
                        flag_waddr  = cursor_eff[PTR_W-1:0];
                        flag_wdata  = glyph_byte[FLAG_W-1:0];
                        cursor_next = cursor_eff + CNT_W'(1);
                        if (glyph_byte[FLAG_REPEAT])
                        begin
                            rep_next  = 1'b1;
                            held_next = glyph_byte[FLAG_W-1:0];
                        end
                        else if (enter_x_on_byte)
                        begin
                            phase_next  = PH_X;
                            cursor_next = '0;
                            run_next    = '0;
                            hbp_next    = 1'b0;
                        end
                    end
                end
                PH_X, PH_Y:
                begin
                    if (f_short)
                    begin
                        commit = 1'b1;
                        delta  = f_same ? COORD_W'(glyph_byte)
                                        : COORD_W'(0) - COORD_W'(glyph_byte);
                    end
                    else if (hbp_reg)
                    begin
                        commit   = 1'b1;
                        hbp_next = 1'b0;
                        delta    = {hb_reg, glyph_byte};
                    end
                    else
                    begin
                        hb_next  = glyph_byte;
                        hbp_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        else if (cmd.repeat_step)
        begin
            if ((rep_cnt_reg != '0) && !at_end)
            begin
                flag_we      = 1'b1;
                cursor_next  = cursor_reg + CNT_W'(1);
                rep_cnt_next = rep_cnt_reg - BYTE_W'(1);
            end
            else
            begin
                rep_next = 1'b0;
                if (at_end)
                begin
                    phase_next  = PH_X;
                    cursor_next = '0;
                    run_next    = '0;
                    hbp_next    = 1'b0;
                end
            end
        end
        else if (cmd.settle_step && ph_xy)
        begin
            if (at_end)
            begin
                if (sel_x)
                begin
                    phase_next  = PH_Y;
                    cursor_next = '0;
                    run_next    = '0;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            else if (!f_short && f_same && (sel_x || out_free))
            begin
                commit = 1'b1;
            end
        end

        // Complete the coordinate at the cursor
        if (commit)
        begin
            run_next    = sum;
            cursor_next = cursor_reg + CNT_W'(1);
        end
    end

    assign sum      = run_reg + delta;
    assign x_we     = commit && sel_x;
    assign out_load = commit && !sel_x;
    assign rd_addr  = cursor_next[PTR_W-1:0];

    // Status to the controller
    assign stat.phase_y       = (phase_reg == PH_Y);
    assign stat.out_free      = out_free;
    assign stat.acc_repeat    = (phase_eff == PH_FLAGS) && rep_eff;
    assign stat.acc_settle    = enter_x_on_byte || commit_on_byte;
    assign stat.rep_busy      = (rep_cnt_reg != '0) && !at_end;
    assign stat.rep_to_settle = at_end;
    assign stat.settle_exit   = !ph_xy || (at_end && !sel_x) ||
                                (!at_end && !(!f_short && f_same));
    assign stat.out_load      = out_load;
    assign stat.cursor_over   = (cursor_reg > total_reg);

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FLAGS;
            cursor_reg    <= '0;
            total_reg     <= CNT_W'(1);
            rep_reg       <= 1'b0;
            rep_cnt_reg   <= '0;
            held_reg      <= '0;
            hbp_reg       <= 1'b0;
            hb_reg        <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cursor_reg    <= cursor_next;
            total_reg     <= total_next;
            rep_reg       <= rep_next;
            rep_cnt_reg   <= rep_cnt_next;
            held_reg      <= held_next;
            hbp_reg       <= hbp_next;
            hb_reg        <= hb_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Drop the point once taken, load a new one when complete
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (point_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Load output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_idx_reg  <= cursor_reg[IDX_W-1:0];
            out_x_reg    <= x_rd_reg;
            out_y_reg    <= sum;
            out_on_reg   <= flag_rd_reg[FLAG_ON_CURVE];
            out_last_reg <= ((cursor_reg + CNT_W'(1)) == total_reg);
        end
    end

    // Flag store: read at the next cursor, forward a same-address write
    always_ff @(posedge clk)
    begin
        if (flag_we)
            flag_mem[flag_waddr] <= flag_wdata;
        if (flag_we && (flag_waddr == rd_addr))
            flag_rd_reg <= flag_wdata;
        else
            flag_rd_reg <= flag_mem[rd_addr];
    end

    // X store: read at the next cursor, forward a same-address write
    always_ff @(posedge clk)
    begin
        if (x_we)
            x_mem[cursor_reg[PTR_W-1:0]] <= sum;
        if (x_we && (cursor_reg[PTR_W-1:0] == rd_addr))
            x_rd_reg <= sum;
        else
            x_rd_reg <= x_mem[rd_addr];
    end

    assign point_valid  = out_valid_reg;
    assign point_index  = out_idx_reg;
    assign x_coord      = $signed(out_x_reg);
    assign y_coord      = $signed(out_y_reg);
    assign on_curve     = out_on_reg;
    assign end_of_glyph = out_last_reg;

endmodule
